/* rtl/first_fit_region_allocator_core_macros.svh */
// ----------------------------------------------------------------------------
// first_fit_region_allocator_core_macros
// Assertion macros used by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_REGION_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_REGION_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define FFRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset
`define FFRA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FFRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define FFRA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/ffra_pkg.sv */
// ----------------------------------------------------------------------------
// ffra_pkg
// Types and constants of the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int TABLE_ENTRIES_DEF = 512;
  localparam int PAGE_W  = 20;
  localparam int COUNT_W = 21;
  localparam int ENTRY_W = PAGE_W + COUNT_W;

  // Operation codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FREE_FULL = 2'd3;

  // Register indexes
  localparam logic REG_BASE = 1'b0;
  localparam logic REG_POOL = 1'b1;

  localparam logic [31:0] POOL_RESET = 32'd8192;

  // Classified transaction: page count for allocate, first page for release
  typedef struct packed {
    logic               op;
    logic [COUNT_W-1:0] arg;
  } job_t;

endpackage

/* rtl/first_fit_region_allocator_core.sv */
// Each transaction scans both tables up to the larger high-water mark; the back
// end starts a new transaction only after it is through with the last one.
// The scan reads one entry of each table RAM per cycle.
// Up to two more transactions wait in the front queue while one is scanned.
// Synchronous active-low reset; tables are rebuilt after reset and after
// every pool_bytes write, once the back end is idle.
// ----------------------------------------------------------------------------
// first_fit_region_allocator_core
// First-fit page region allocator with used and spare region tables.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_core #(
  parameter int TABLE_ENTRIES = ffra_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [31:0] in_request_bytes,
  input  logic [31:0] in_release_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_region_address,
  output logic [1:0]  out_status,
  output logic [19:0] out_freed_first_page,
  output logic [20:0] out_freed_page_count,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ffra_pkg::*;
`include "first_fit_region_allocator_core_macros.svh"

  logic        base_we, pool_we;
  logic [31:0] base_r, base_nxt, pool_r, pool_nxt;
  logic        q_full, q_ready, push, pop;
  job_t        push_job, head_job;

  // Register file
  assign cfg_pready = 1'b1;
  assign base_we = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_BASE);
  assign pool_we = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_POOL);
  assign base_nxt = base_we ? cfg_pwdata : base_r;
  assign pool_nxt = pool_we ? cfg_pwdata : pool_r;
  assign cfg_prdata = (cfg_paddr[2] == REG_POOL) ? pool_r : base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      pool_r <= POOL_RESET;
    end else begin
      base_r <= base_nxt;
      pool_r <= pool_nxt;
    end
  end

  ffra_front u_front (
    .in_valid(in_valid), .in_opcode(in_opcode), .in_request_bytes(in_request_bytes),
    .in_release_address(in_release_address), .pool_base(base_r),
    .queue_full(q_full), .in_stall(in_stall), .push(push), .push_job(push_job)
  );

  ffra_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_job(push_job), .pop(pop),
    .full(q_full), .not_empty(q_ready), .head_job(head_job)
  );

  ffra_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk(clk), .rst_n(rst_n), .job_ready(q_ready), .job(head_job), .pop(pop),
    .init_req(pool_we), .pool_bytes(pool_r), .pool_base(base_r),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_region_address(out_region_address), .out_status(out_status),
    .out_freed_first_page(out_freed_first_page),
    .out_freed_page_count(out_freed_page_count)
  );

  // Unmap report only on a successful release
  `FFRA_ASSERT_IMP(a_freed_only_ok, clk, rst_n, out_valid && (out_status != ST_OK), (out_freed_page_count == '0) && (out_freed_first_page == '0), "freed pages reported on failed transaction")
  `FFRA_ASSERT_IMP(a_release_no_addr, clk, rst_n, out_valid && (out_freed_page_count != '0), (out_status == ST_OK) && (out_region_address == '0), "release result carries an address")
  // A full queue that is not popped keeps the input stalled
  `FFRA_ASSERT_NXT(a_queue_drain, clk, rst_n, q_full && !pop, in_stall, "queue full but input not stalled")

endmodule

/* rtl/ffra_ram.sv */
// ----------------------------------------------------------------------------
// ffra_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/ffra_queue.sv */
// ----------------------------------------------------------------------------
// ffra_queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module ffra_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ffra_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output ffra_pkg::job_t head_job
);
  import ffra_pkg::*;

  job_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign full      = (fill_r == 2'd2);
  assign not_empty = (fill_r != 2'd0);
  assign head_job  = slot_r[rd_ptr_r];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store pushed transaction
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* rtl/ffra_front.sv */
// ----------------------------------------------------------------------------
// ffra_front
// Accepts requests and turns them into page-based jobs.
// ----------------------------------------------------------------------------
module ffra_front (
  input  logic           in_valid,
  input  logic           in_opcode,
  input  logic [31:0]    in_request_bytes,
  input  logic [31:0]    in_release_address,
  input  logic [31:0]    pool_base,
  input  logic           queue_full,
  output logic           in_stall,
  output logic           push,
  output ffra_pkg::job_t push_job
);
  import ffra_pkg::*;

  logic [COUNT_W-1:0] pages;
  logic [31:0]        offset;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Round bytes up to pages, at least one; release address to pool page
  always_comb begin
    pages = {1'b0, in_request_bytes[31:12]} + COUNT_W'(|in_request_bytes[11:0]);
    if (pages == '0) begin
      pages = COUNT_W'(1);
    end
    offset       = in_release_address - pool_base;
    push_job.op  = in_opcode;
    push_job.arg = (in_opcode == OP_ALLOC) ? pages : {1'b0, offset[31:12]};
  end

endmodule

/* rtl/ffra_back.sv */
// ----------------------------------------------------------------------------
// ffra_back
// Scans the used and spare tables, updates them and registers the result.
// ----------------------------------------------------------------------------
module ffra_back #(
  parameter int TABLE_ENTRIES = ffra_pkg::TABLE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_ready,
  input  ffra_pkg::job_t job,
  output logic           pop,
  input  logic           init_req,
  input  logic [31:0]    pool_bytes,
  input  logic [31:0]    pool_base,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [31:0]    out_region_address,
  output logic [1:0]     out_status,
  output logic [19:0]    out_freed_first_page,
  output logic [20:0]    out_freed_page_count
);
  import ffra_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] NUM = CW'(TABLE_ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic        init_r, init_nxt;
  logic [CW-1:0] hw_u_r, hw_u_nxt, hw_s_r, hw_s_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        pend_r, pend_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  job_t        job_r, job_nxt;
  logic        s_hit_r, s_hit_nxt, u_hit_r, u_hit_nxt;
  logic [AW-1:0] s_idx_r, s_idx_nxt, u_idx_r, u_idx_nxt;
  logic [PAGE_W-1:0]  s_fp_r, s_fp_nxt, u_fp_r, u_fp_nxt;
  logic [COUNT_W-1:0] s_cnt_r, s_cnt_nxt, u_cnt_r, u_cnt_nxt;
  logic        oval_r, oval_nxt;
  logic [31:0] oaddr_r, oaddr_nxt;
  logic [1:0]  ostat_r, ostat_nxt;
  logic [PAGE_W-1:0]  ofp_r, ofp_nxt;
  logic [COUNT_W-1:0] ocnt_r, ocnt_nxt;

  logic               u_we, s_we;
  logic [AW-1:0]      u_wa, s_wa;
  logic [ENTRY_W-1:0] u_wd, s_wd, u_q, s_q;
  logic [CW-1:0]      lim;
  logic               u_in, s_in, s_match, u_match;
  logic [PAGE_W-1:0]  u_fp_e, s_fp_e;
  logic [COUNT_W-1:0] u_cnt_e, s_cnt_e;
  logic [PAGE_W-1:0]  pool_pages;
  logic [COUNT_W-1:0] init_cnt;
  logic               s_room, u_room;
  logic [AW-1:0]      s_slot, u_slot;

  ffra_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_used_ram (
    .clk(clk), .wr_en(u_we), .wr_addr(u_wa), .wr_data(u_wd),
    .rd_addr(cnt_r[AW-1:0]), .rd_data(u_q)
  );

  ffra_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_spare_ram (
    .clk(clk), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
    .rd_addr(cnt_r[AW-1:0]), .rd_data(s_q)
  );

  assign out_valid            = oval_r;
  assign out_region_address   = oaddr_r;
  assign out_status           = ostat_r;
  assign out_freed_first_page = ofp_r;
  assign out_freed_page_count = ocnt_r;

  // Entries at or past the high-water mark read as empty; empty-slot hits stay
  // below the mark so that a slot at the mark always advances it
  always_comb begin
    u_in    = CW'(pidx_r) < hw_u_r;
    s_in    = CW'(pidx_r) < hw_s_r;
    u_fp_e  = u_in ? u_q[ENTRY_W-1:COUNT_W] : '0;
    u_cnt_e = u_in ? u_q[COUNT_W-1:0] : '0;
    s_fp_e  = s_in ? s_q[ENTRY_W-1:COUNT_W] : '0;
    s_cnt_e = s_in ? s_q[COUNT_W-1:0] : '0;
    if (job_r.op == OP_ALLOC) begin
      s_match = s_cnt_e >= job_r.arg;
      u_match = u_in && (u_cnt_e == '0);
    end else begin
      s_match = s_in && (s_cnt_e == '0);
      u_match = (u_cnt_e != '0) && (u_fp_e == job_r.arg[PAGE_W-1:0]);
    end
    lim        = (hw_u_r > hw_s_r) ? hw_u_r : hw_s_r;
    pool_pages = pool_bytes[31:12];
    init_cnt   = (pool_pages >= PAGE_W'(2)) ? {1'b0, pool_pages - PAGE_W'(2)} : '0;
    s_room     = s_hit_r || (hw_s_r < NUM);
    u_room     = u_hit_r || (hw_u_r < NUM);
    s_slot     = s_hit_r ? s_idx_r : hw_s_r[AW-1:0];
    u_slot     = u_hit_r ? u_idx_r : hw_u_r[AW-1:0];
  end

  // Sequence init, scan and update
  always_comb begin
    state_nxt = state_r;
    init_nxt  = init_r;
    hw_u_nxt  = hw_u_r;
    hw_s_nxt  = hw_s_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    pidx_nxt  = pidx_r;
    job_nxt   = job_r;
    s_hit_nxt = s_hit_r;
    s_idx_nxt = s_idx_r;
    s_fp_nxt  = s_fp_r;
    s_cnt_nxt = s_cnt_r;
    u_hit_nxt = u_hit_r;
    u_idx_nxt = u_idx_r;
    u_fp_nxt  = u_fp_r;
    u_cnt_nxt = u_cnt_r;
    oval_nxt  = oval_r && out_stall;
    oaddr_nxt = oaddr_r;
    ostat_nxt = ostat_r;
    ofp_nxt   = ofp_r;
    ocnt_nxt  = ocnt_r;
    pop  = 1'b0;
    u_we = 1'b0;
    s_we = 1'b0;
    u_wa = '0;
    s_wa = '0;
    u_wd = '0;
    s_wd = '0;

    // Record first hit of each table
    if (pend_r && !s_hit_r && s_match) begin
      s_hit_nxt = 1'b1;
      s_idx_nxt = pidx_r;
      s_fp_nxt  = s_fp_e;
      s_cnt_nxt = s_cnt_e;
    end
    if (pend_r && !u_hit_r && u_match) begin
      u_hit_nxt = 1'b1;
      u_idx_nxt = pidx_r;
      u_fp_nxt  = u_fp_e;
      u_cnt_nxt = u_cnt_e;
    end

    case (state_r)
      S_IDLE: begin
        if (init_r) begin
          u_we     = 1'b1;
          s_we     = 1'b1;
          u_wd     = {PAGE_W'(0), COUNT_W'(2)};
          s_wd     = {PAGE_W'(2), init_cnt};
          hw_u_nxt = CW'(1);
          hw_s_nxt = CW'(1);
          init_nxt = 1'b0;
        end else if (job_ready) begin
          pop       = 1'b1;
          job_nxt   = job;
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          s_hit_nxt = 1'b0;
          u_hit_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r < lim) begin
          cnt_nxt  = cnt_r + CW'(1);
          pend_nxt = 1'b1;
          pidx_nxt = cnt_r[AW-1:0];
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!oval_r || !out_stall) begin
          oval_nxt  = 1'b1;
          oaddr_nxt = '0;
          ofp_nxt   = '0;
          ocnt_nxt  = '0;
          state_nxt = S_IDLE;
          if (job_r.op == OP_ALLOC) begin
            if (!s_hit_r || !u_room) begin
              ostat_nxt = ST_NO_SPACE;
            end else begin
              ostat_nxt = ST_OK;
              u_we = 1'b1;
              u_wa = u_slot;
              u_wd = {s_fp_r, job_r.arg};
              s_we = 1'b1;
              s_wa = s_idx_r;
              s_wd = {s_fp_r + job_r.arg[PAGE_W-1:0], s_cnt_r - job_r.arg};
              if (!u_hit_r) begin
                hw_u_nxt = hw_u_r + CW'(1);
              end
              oaddr_nxt = pool_base + {s_fp_r, 12'h000};
            end
          end else begin
            if (!u_hit_r) begin
              ostat_nxt = ST_NOT_FOUND;
            end else if (!s_room) begin
              ostat_nxt = ST_FREE_FULL;
            end else begin
              ostat_nxt = ST_OK;
              s_we = 1'b1;
              s_wa = s_slot;
              s_wd = {u_fp_r, u_cnt_r};
              u_we = 1'b1;
              u_wa = u_idx_r;
              u_wd = '0;
              if (!s_hit_r) begin
                hw_s_nxt = hw_s_r + CW'(1);
              end
              ofp_nxt  = u_fp_r;
              ocnt_nxt = u_cnt_r;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Table rebuild request wins over clearing
    if (init_req) begin
      init_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      init_r  <= 1'b1;
      hw_u_r  <= '0;
      hw_s_r  <= '0;
      pend_r  <= 1'b0;
      s_hit_r <= 1'b0;
      u_hit_r <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      hw_u_r  <= hw_u_nxt;
      hw_s_r  <= hw_s_nxt;
      pend_r  <= pend_nxt;
      s_hit_r <= s_hit_nxt;
      u_hit_r <= u_hit_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // Hold scan and result payload
  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    pidx_r  <= pidx_nxt;
    job_r   <= job_nxt;
    s_idx_r <= s_idx_nxt;
    s_fp_r  <= s_fp_nxt;
    s_cnt_r <= s_cnt_nxt;
    u_idx_r <= u_idx_nxt;
    u_fp_r  <= u_fp_nxt;
    u_cnt_r <= u_cnt_nxt;
    oaddr_r <= oaddr_nxt;
    ostat_r <= ostat_nxt;
    ofp_r   <= ofp_nxt;
    ocnt_r  <= ocnt_nxt;
  end

endmodule

/* bench/first_fit_region_allocator_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator_core_test
// Self-checking bench: allocate/release transactions against a local model of
// the used and spare region tables, under random idling and a long result stall.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_core_test;
  import ffra_pkg::*;

  localparam int ENTRIES = TABLE_ENTRIES_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  status;
    logic [19:0] first_page;
    logic [20:0] page_count;
  } outcome_t;

  typedef struct {
    logic        op;
    logic [31:0] req;
    logic [31:0] rel;
    logic        fixed;
    outcome_t    want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = 1'b0;
  logic [31:0] in_request_bytes = '0;
  logic [31:0] in_release_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_region_address;
  logic [1:0]  out_status;
  logic [19:0] out_freed_first_page;
  logic [20:0] out_freed_page_count;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Model state
  logic [31:0] pool_base;
  logic [31:0] pool_size;
  logic [19:0] used_page [ENTRIES];
  logic [20:0] used_cnt [ENTRIES];
  logic [19:0] spare_page [ENTRIES];
  logic [20:0] spare_cnt [ENTRIES];
  logic [31:0] live_addrs [$];

  outcome_t pending_outcomes [$];
  int       error_count = 0;
  int       idle_cycles = 0;
  bit       calm = 1'b0;
  bit       hold_off = 1'b0;
  bit       done = 1'b0;

  first_fit_region_allocator_core u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Rebuild tables for current pool size
  function automatic void rebuild_tables();
    logic [31:0] pages;
    pages = pool_size / 4096;
    for (int i = 0; i < ENTRIES; i++) begin
      used_page[i] = '0; used_cnt[i] = '0; spare_page[i] = '0; spare_cnt[i] = '0;
    end
    used_cnt[0] = 21'd2;
    spare_page[0] = 20'd2;
    spare_cnt[0] = (pages >= 32'd2) ? 21'(pages - 32'd2) : '0;
    live_addrs.delete();
    live_addrs.push_back(pool_base);
  endfunction

  function automatic outcome_t allocate_or_release(input logic op, input logic [31:0] req,
                                                   input logic [31:0] rel);
    outcome_t r;
    logic [32:0] pages;
    logic [31:0] page;
    int s, u;
    r = '0; s = -1; u = -1;
    if (op == OP_ALLOC) begin
      pages = ({1'b0, req} + 33'd4095) >> 12;
      if (pages == 33'd0) pages = 33'd1;
      for (int i = 0; i < ENTRIES; i++) if (s < 0 && {12'd0, spare_cnt[i]} >= pages) s = i;
      for (int i = 0; i < ENTRIES; i++) if (u < 0 && used_cnt[i] == '0) u = i;
      if (s < 0 || u < 0) begin
        r.status = ST_NO_SPACE;
      end else begin
        used_page[u] = spare_page[s];
        used_cnt[u] = pages[20:0];
        spare_page[s] = spare_page[s] + pages[19:0];
        spare_cnt[s] = spare_cnt[s] - pages[20:0];
        r.addr = pool_base + {used_page[u], 12'd0};
        r.status = ST_OK;
        live_addrs.push_back(r.addr);
      end
    end else begin
      page = (rel - pool_base) >> 12;
      for (int i = 0; i < ENTRIES; i++)
        if (s < 0 && used_cnt[i] != '0 && {12'd0, used_page[i]} == page) s = i;
      for (int i = 0; i < ENTRIES; i++) if (u < 0 && spare_cnt[i] == '0) u = i;
      if (s < 0) r.status = ST_NOT_FOUND;
      else if (u < 0) r.status = ST_FREE_FULL;
      else begin
        spare_page[u] = used_page[s];
        spare_cnt[u] = used_cnt[s];
        r.first_page = used_page[s];
        r.page_count = used_cnt[s];
        used_page[s] = '0;
        used_cnt[s] = '0;
        r.status = ST_OK;
      end
    end
    return r;
  endfunction

  task automatic write_register(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_paddr = {idx, 2'b00}; cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    if (idx == REG_BASE) pool_base = value;
    else begin
      pool_size = value;
      rebuild_tables();
    end
  endtask

  // Offer one transaction; hold until accepted, then leave valid for the next
  task automatic send_item(input logic op, input logic [31:0] req, input logic [31:0] rel,
                           input bit fixed, input outcome_t want);
    outcome_t predicted;
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; in_opcode <= op; in_request_bytes <= req; in_release_address <= rel;
    do @(posedge clk); while (in_stall);
    predicted = allocate_or_release(op, req, rel);
    if (fixed && predicted != want) report_mismatch("table row", predicted[74:43], want[74:43]);
    pending_outcomes.push_back(predicted);
    @(negedge clk);
  endtask

  // Drop valid and wait for every result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (530) @(posedge clk);
  endtask

  task automatic random_item();
    logic [31:0] req, rel;
    int pick;
    pick = $urandom_range(99);
    req = $urandom_range(3) == 0 ? $urandom : $urandom_range(40000);
    if (live_addrs.size() > 0 && pick < 45) rel = live_addrs[$urandom_range(live_addrs.size() - 1)];
    else rel = (pick < 55) ? $urandom : pool_base + ($urandom_range(60) << 12) + $urandom_range(1);
    send_item(pick < 55 ? OP_ALLOC : OP_RELEASE, req, rel, 1'b0, '0);
  endtask

  // Result side: stall at random, once hold off long
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= !calm && ($urandom_range(99) < 9);
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result", out_region_address, '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_region_address !== want.addr)
          report_mismatch("region_address", out_region_address, want.addr);
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_freed_first_page !== want.first_page)
          report_mismatch("freed_first_page", 32'(out_freed_first_page), 32'(want.first_page));
        if (out_freed_page_count !== want.page_count)
          report_mismatch("freed_page_count", 32'(out_freed_page_count), 32'(want.page_count));
      end
    end
  end

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel || hold_off || done)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  row_t rows [$];

  function automatic row_t mk(input logic op, input logic [31:0] req, input logic [31:0] rel,
                              input bit fixed, input logic [31:0] a, input logic [1:0] st,
                              input logic [19:0] fp, input logic [20:0] pc);
    row_t r;
    r.op = op; r.req = req; r.rel = rel; r.fixed = fixed;
    r.want = '{addr: a, status: st, first_page: fp, page_count: pc};
    return r;
  endfunction

  initial begin
    pool_base = '0;
    pool_size = POOL_RESET;
    rebuild_tables();
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    repeat (3) @(negedge clk);

    // Reset pool has no spare pages
    rows.push_back(mk(OP_ALLOC, 32'd0, '0, 1'b1, '0, ST_NO_SPACE, '0, '0));
    rows.push_back(mk(OP_RELEASE, '0, 32'h0000_1000, 1'b1, '0, ST_NOT_FOUND, '0, '0));
    foreach (rows[i]) send_item(rows[i].op, rows[i].req, rows[i].rel, rows[i].fixed, rows[i].want);
    drain();

    write_register(REG_BASE, 32'h1000_0000);
    write_register(REG_POOL, 32'h0010_0000);
    rows.delete();
    rows.push_back(mk(OP_ALLOC, 32'd0, '0, 1'b1, 32'h1000_2000, ST_OK, '0, '0));
    rows.push_back(mk(OP_ALLOC, 32'd4096, '0, 1'b1, 32'h1000_3000, ST_OK, '0, '0));
    rows.push_back(mk(OP_ALLOC, 32'd4097, '0, 1'b1, 32'h1000_4000, ST_OK, '0, '0));
    rows.push_back(mk(OP_ALLOC, 32'hFFFF_FFFF, '0, 1'b1, '0, ST_NO_SPACE, '0, '0));
    rows.push_back(mk(OP_RELEASE, '0, 32'h1000_3FFF, 1'b1, '0, ST_OK, 20'd3, 21'd1));
    rows.push_back(mk(OP_RELEASE, '0, 32'h1000_3000, 1'b1, '0, ST_NOT_FOUND, '0, '0));
    rows.push_back(mk(OP_RELEASE, '0, 32'h1000_0000, 1'b1, '0, ST_OK, 20'd0, 21'd2));
    rows.push_back(mk(OP_ALLOC, 32'd1, '0, 1'b0, '0, ST_OK, '0, '0));
    rows.push_back(mk(OP_RELEASE, '0, 32'hFFFF_FFFF, 1'b1, '0, ST_NOT_FOUND, '0, '0));
    rows.push_back(mk(OP_RELEASE, '0, 32'h1000_4000, 1'b0, '0, ST_OK, '0, '0));
    foreach (rows[i]) send_item(rows[i].op, rows[i].req, rows[i].rel, rows[i].fixed, rows[i].want);
    drain();

    // Largest pool and high base: address wrap
    write_register(REG_BASE, 32'hFFFF_F000);
    write_register(REG_POOL, 32'hFFFF_F000);
    send_item(OP_ALLOC, 32'hFFFF_FFFF, '0, 1'b0, '0);
    send_item(OP_ALLOC, 32'h0000_8000, '0, 1'b0, '0);
    for (int i = 0; i < 150; i++) random_item();
    // Hold off results so the input stalls
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 10; i++) random_item();
    join
    drain();

    // Small pool, many tiny regions
    write_register(REG_POOL, 32'h0020_0000);
    calm = 1'b1;
    for (int i = 0; i < 40; i++) send_item(OP_ALLOC, 32'd0, '0, 1'b0, '0);
    calm = 1'b0;
    for (int i = 0; i < 160; i++) random_item();
    drain();
    write_register(REG_BASE, $urandom & 32'hFFFF_F000);
    write_register(REG_POOL, 32'h0000_4000 + ($urandom_range(4000) << 12));
    for (int i = 0; i < 200; i++) random_item();
    drain();
    done = 1'b1;
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
